@@ hw/rtl/rwtp_pkg.sv @@
// Package for the row well tap placer: register indexes, tap kinds, widths.
// Used by row_well_tap_placer; depends on nothing else.
package rwtp_pkg;

	localparam int COL_W    = 12;
	localparam int CW_W     = 7;
	localparam int MAX_SITES = 4096;
	localparam int COL_LIMIT = (MAX_SITES < 4096) ? MAX_SITES : 4096;
	localparam logic [COL_W-1:0] LAST_COL = COL_W'(COL_LIMIT - 1);

	localparam logic [COL_W-1:0] INTERVAL_RST = 12'd16;
	localparam logic [COL_W-1:0] PHASE_RST    = 12'd0;
	localparam logic [CW_W-1:0]  WIDTH_RST    = 7'd1;

	typedef enum logic [1:0] {
		REG_TAP_INTERVAL = 2'd0,
		REG_TAP_PHASE    = 2'd1,
		REG_CELL_WIDTH   = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_PERIODIC = 2'd0,
		KIND_LEFT     = 2'd1,
		KIND_RIGHT    = 2'd2
	} tap_kind_t;

endpackage

@@ hw/rtl/row_well_tap_placer.sv @@
// Row well tap placer: one site per transfer in, tap columns out.
// A site waits in the input register; its taps leave from the result register. One
// site per cycle sustained while each site yields at most one tap and m_tready is high;
// run-closing sites emit up to 3 taps and hold the next site in the input register
// until the result register drains (one a cycle while m_tready is high). Any write to
// tap_interval or tap_phase starts a remainder pass; no site is taken meanwhile.
// arst_n clears control state and loads register defaults. Depends on rwtp_pkg.
module row_well_tap_placer
	import rwtp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] site_free, [7:1] zero
	input  logic        s_tlast,   // last_site
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [11:0] tap_col, [15:12] zero
	output logic [1:0]  m_tuser,   // [1:0] tap_kind
	output logic        m_tlast,   // last_of_run
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data
);

	// configuration
	logic [COL_W-1:0] interval_q, tap_phase_q;
	logic [CW_W-1:0]  cell_width_q;

	// row state
	logic [COL_W-1:0] col_q, phase_q, phase_mod_q, run_start_q, first_tap_q, last_tap_q;
	logic             run_active_q, tap_seen_q;

	// remainder unit
	logic [3:0]       red_cnt_q;
	logic [COL_W-1:0] dvd_a_q, dvd_b_q, rem_a_q, rem_b_q;
	logic [COL_W:0]   red_ta, red_tb;
	logic [COL_W-1:0] red_ra, red_rb;
	logic             busy;

	// input register
	logic             free_s1, last_s1, vld_s1;

	// result register
	logic [COL_W-1:0] res_col_q [3];
	tap_kind_t        res_kind_q [3];
	logic [1:0]       res_cnt_q;

	// per-site logic
	logic [COL_W-1:0] iv, half, p, lo, hi, rpos;
	logic [CW_W-1:0]  cw;
	logic             last_eff, start_run, per, seen_n, close;
	logic [COL_W-1:0] start_n, first_n, lastt_n;
	logic [COL_W:0]   hi_p1, lo_cw, p_p1;
	logic             en_l, en_r;
	logic [COL_W-1:0] cand_col [3];
	tap_kind_t        cand_kind [3];
	logic [2:0]       cand_en;
	logic [COL_W-1:0] new_col [3];
	tap_kind_t        new_kind [3];
	logic [1:0]       new_n;
	logic             pop, adv, s_take;

	assign iv   = (interval_q == '0) ? COL_W'(1) : interval_q;
	assign cw   = (cell_width_q == '0) ? CW_W'(1) : cell_width_q;
	assign half = iv >> 1;
	assign busy = (red_cnt_q != '0);

	// one restoring remainder step for each operand
	always_comb begin
		red_ta = {rem_a_q, dvd_a_q[COL_W-1]};
		red_tb = {rem_b_q, dvd_b_q[COL_W-1]};
		red_ra = (red_ta >= {1'b0, iv}) ? COL_W'(red_ta - {1'b0, iv}) : red_ta[COL_W-1:0];
		red_rb = (red_tb >= {1'b0, iv}) ? COL_W'(red_tb - {1'b0, iv}) : red_tb[COL_W-1:0];
	end

	always_comb begin
		p         = (col_q == '0) ? phase_mod_q : phase_q;
		last_eff  = last_s1 || (col_q >= LAST_COL);
		start_run = free_s1 && !run_active_q;
		per       = free_s1 && (p == '0);
		start_n   = start_run ? col_q : run_start_q;
		seen_n    = (start_run ? 1'b0 : tap_seen_q) || per;
		first_n   = (per && (start_run || !tap_seen_q)) ? col_q :
		            (start_run ? '0 : first_tap_q);
		lastt_n   = per ? col_q : (start_run ? '0 : last_tap_q);
		close     = (run_active_q || free_s1) && (!free_s1 || last_eff);
		lo        = start_n;
		hi        = free_s1 ? col_q : col_q - COL_W'(1);
		hi_p1     = {1'b0, hi} + (COL_W+1)'(1);
		lo_cw     = {1'b0, lo} + (COL_W+1)'(cw);
		rpos      = (hi_p1 >= lo_cw) ? COL_W'(hi_p1 - (COL_W+1)'(cw)) : lo;
		if (!seen_n) begin
			en_l = 1'b1;
			en_r = (hi - lo) > half;
		end else begin
			en_l = (first_n - lo) > half;
			en_r = (hi - lastt_n) > half;
		end
		p_p1 = {1'b0, p} + (COL_W+1)'(1);

		cand_col[0]  = col_q;
		cand_kind[0] = KIND_PERIODIC;
		cand_col[1]  = lo;
		cand_kind[1] = KIND_LEFT;
		cand_col[2]  = rpos;
		cand_kind[2] = KIND_RIGHT;
		cand_en      = {close && en_r, close && en_l, per};

		new_n = '0;
		for (int i = 0; i < 3; i++) begin
			new_col[i]  = '0;
			new_kind[i] = KIND_PERIODIC;
		end
		for (int i = 0; i < 3; i++) begin
			if (cand_en[i]) begin
				new_col[new_n]  = cand_col[i];
				new_kind[new_n] = cand_kind[i];
				new_n           = new_n + 2'd1;
			end
		end
	end

	assign m_tvalid = (res_cnt_q != '0);
	assign m_tdata  = {4'b0, res_col_q[0]};
	assign m_tuser  = res_kind_q[0];
	assign m_tlast  = (res_cnt_q == 2'd1);
	assign pop      = m_tvalid && m_tready;
	assign adv      = vld_s1 && ((res_cnt_q == '0) || ((res_cnt_q == 2'd1) && pop));
	assign s_tready = !busy && !cfg_we && (!vld_s1 || adv);
	assign s_take   = s_tvalid && s_tready;

	// configuration and remainder pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q   <= INTERVAL_RST;
			tap_phase_q  <= PHASE_RST;
			cell_width_q <= WIDTH_RST;
			red_cnt_q    <= '0;
		end else begin
			if (cfg_we) begin
				unique case (reg_idx_t'(cfg_index))
					REG_TAP_INTERVAL: interval_q   <= cfg_data;
					REG_TAP_PHASE:    tap_phase_q  <= cfg_data;
					REG_CELL_WIDTH:   cell_width_q <= cfg_data[CW_W-1:0];
					default: ;
				endcase
			end
			if (cfg_we && (cfg_index == REG_TAP_INTERVAL || cfg_index == REG_TAP_PHASE))
				red_cnt_q <= 4'd13;
			else if (busy)
				red_cnt_q <= red_cnt_q - 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (red_cnt_q == 4'd13) begin
			dvd_a_q <= tap_phase_q;
			dvd_b_q <= phase_q;
			rem_a_q <= '0;
			rem_b_q <= '0;
		end else begin
			dvd_a_q <= dvd_a_q << 1;
			dvd_b_q <= dvd_b_q << 1;
			rem_a_q <= red_ra;
			rem_b_q <= red_rb;
		end
	end

	// row state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q        <= '0;
			phase_q      <= '0;
			phase_mod_q  <= '0;
			run_active_q <= 1'b0;
			run_start_q  <= '0;
			first_tap_q  <= '0;
			last_tap_q   <= '0;
			tap_seen_q   <= 1'b0;
		end else if (red_cnt_q == 4'd1) begin
			phase_mod_q <= red_ra;
			phase_q     <= red_rb;
		end else if (adv) begin
			run_start_q <= start_n;
			first_tap_q <= first_n;
			last_tap_q  <= lastt_n;
			tap_seen_q  <= seen_n;
			if (last_eff) begin
				col_q        <= '0;
				phase_q      <= '0;
				run_active_q <= 1'b0;
			end else begin
				col_q        <= col_q + COL_W'(1);
				phase_q      <= (p_p1 >= {1'b0, iv}) ? '0 : p_p1[COL_W-1:0];
				run_active_q <= (run_active_q || free_s1) && !close;
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_take) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_take) begin
			free_s1 <= s_tdata[0];
			last_s1 <= s_tlast;
		end
	end

	// result register, drained from slot 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_cnt_q <= '0;
		end else if (adv) begin
			res_cnt_q <= new_n;
		end else if (pop) begin
			res_cnt_q <= res_cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				res_col_q[i]  <= new_col[i];
				res_kind_q[i] <= new_kind[i];
			end
		end else if (pop) begin
			for (int i = 0; i < 2; i++) begin
				res_col_q[i]  <= res_col_q[i+1];
				res_kind_q[i] <= res_kind_q[i+1];
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_cnt_q != 2'd3 || !vld_s1 || !s_tready)
		else $error("input taken while result register is full");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> (phase_q < iv && phase_mod_q < iv))
		else $error("phase counter out of range");

	a_cfg_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && (cfg_index == REG_TAP_INTERVAL || cfg_index == REG_TAP_PHASE))
		|=> !s_tready)
		else $error("site taken during remainder pass");

	a_s1_keep: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !adv) |=> vld_s1)
		else $error("pending site lost");
`endif

endmodule

@@ test/tb_row_well_tap_placer.sv @@
// Self-checking testbench for row_well_tap_placer: streams placement rows in,
// predicts every tap from its own row/run tracker and compares each transfer out.
// Depends on rwtp_pkg and row_well_tap_placer only.
module tb_row_well_tap_placer
	import rwtp_pkg::*;
();

	localparam int QUIET_LIMIT = 1000;

	typedef struct packed {
		logic [COL_W-1:0] col;
		tap_kind_t        kind;
		logic             last;
	} tap_rec_t;

	typedef enum logic [1:0] {RX_OPEN, RX_THIRDS, RX_COIN, RX_CHOKED} rx_mode_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;   // [0] site_free, [7:1] zero
	logic        s_tlast = 1'b0;   // last_site
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;          // [11:0] tap_col, [15:12] zero
	logic [1:0]  m_tuser;          // [1:0] tap_kind
	logic        m_tlast;          // last_of_run
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = 2'd0;
	logic [11:0] cfg_data = 12'd0;

	row_well_tap_placer u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// register copies
	logic [COL_W-1:0] interval_reg = INTERVAL_RST;
	logic [COL_W-1:0] phase_reg    = PHASE_RST;
	logic [CW_W-1:0]  width_reg    = WIDTH_RST;

	// row and run tracking
	int col_count   = 0;
	int phase_count = 0;
	bit run_open    = 1'b0;
	int run_lo      = 0;
	int first_col   = 0;
	int last_col    = 0;
	bit tap_found   = 1'b0;

	tap_rec_t pending_taps[$];
	tap_rec_t want;

	int mismatch_count = 0;
	int sites_sent     = 0;
	int taps_checked   = 0;
	int reg_writes     = 0;
	int burst_left     = 0;
	int quiet_cycles   = 0;

	rx_mode_t    rx_mode = RX_OPEN;
	int          rx_span = 0;
	logic [7:0]  rx_tick = 8'd0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		$display("%0t tap check: %s", $time, msg);
		mismatch_count++;
	endtask

	function automatic tap_rec_t make_tap(input int col, input tap_kind_t kind);
		tap_rec_t rec;
		rec.col  = COL_W'(col);
		rec.kind = kind;
		rec.last = 1'b0;
		return rec;
	endfunction

	function automatic void predict_taps(input bit free, input bit mark);
		int iv, cw, half, col, p, lo, hi, rpos;
		bit row_end;
		tap_rec_t found[$];
		tap_rec_t rec;
		iv = (interval_reg == 0) ? 1 : int'(interval_reg);
		cw = (width_reg == 0) ? 1 : int'(width_reg);
		half = iv / 2;
		col = col_count;
		p = ((col == 0) ? int'(phase_reg) : phase_count) % iv;
		row_end = mark || (col >= int'(LAST_COL));
		if (free) begin
			if (!run_open) begin
				run_open = 1'b1;
				run_lo = col;
				tap_found = 1'b0;
				first_col = 0;
				last_col = 0;
			end
			if (p == 0) begin
				found.push_back(make_tap(col, KIND_PERIODIC));
				if (!tap_found)
					first_col = col;
				last_col = col;
				tap_found = 1'b1;
			end
		end
		if (run_open && (!free || row_end)) begin
			lo = run_lo;
			hi = free ? col : col - 1;
			rpos = (hi + 1 >= lo + cw) ? hi + 1 - cw : lo;
			if (!tap_found) begin
				found.push_back(make_tap(lo, KIND_LEFT));
				if (hi - lo > half)
					found.push_back(make_tap(rpos, KIND_RIGHT));
			end else begin
				if (first_col - lo > half)
					found.push_back(make_tap(lo, KIND_LEFT));
				if (hi - last_col > half)
					found.push_back(make_tap(rpos, KIND_RIGHT));
			end
			run_open = 1'b0;
		end
		foreach (found[i]) begin
			rec = found[i];
			rec.last = (i == found.size() - 1);
			pending_taps.push_back(rec);
		end
		if (row_end) begin
			col_count = 0;
			phase_count = 0;
			run_open = 1'b0;
		end else begin
			col_count = (col + 1) % 4096;
			phase_count = (p + 1 >= iv) ? 0 : p + 1;
		end
	endfunction

	task automatic send_site(input bit free, input bit mark);
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, free};
		s_tlast  <= mark;
		do @(posedge clk); while (!s_tready);
		predict_taps(free, mark);
		sites_sent++;
		if (burst_left > 0)
			burst_left--;
		else begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
			                                         : $urandom_range(0, 6);
		end
	endtask

	// sites[0] is the leftmost; close marks the final one as row end
	task automatic send_row(input logic [31:0] sites, input int len, input bit close);
		for (int i = 0; i < len; i++)
			send_site(sites[i], close && (i == len - 1));
	endtask

	// drop valid, wait for every tap and for the pipeline and remainder pass to drain
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_taps.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [11:0] val);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_TAP_INTERVAL: interval_reg = val;
			REG_TAP_PHASE:    phase_reg = val;
			default:          width_reg = val[CW_W-1:0];
		endcase
		reg_writes++;
	endtask

	task automatic write_config(input logic [11:0] iv, input logic [11:0] ph,
	                            input logic [CW_W-1:0] w);
		write_reg(REG_TAP_INTERVAL, iv);
		write_reg(REG_TAP_PHASE, ph);
		write_reg(REG_CELL_WIDTH, 12'(w));
	endtask

	// reset values: one periodic tap at column 0, then an all-blocked row
	task automatic test_defaults();
		send_row(32'b011, 3, 1'b1);
		send_row(32'b0, 1, 1'b1);
	endtask

	// left and right end taps around one periodic tap; zero width acts as one
	task automatic test_end_taps();
		write_config(12'd4, 12'd1, 7'd0);
		send_row(32'h7f, 7, 1'b1);
	endtask

	// run without periodic tap, right tap clamped back onto the left tap column
	task automatic test_clamp_repeat();
		write_config(12'd6, 12'd0, 7'd64);
		send_row(32'b111110, 6, 1'b1);
	endtask

	// zero interval: every free site is a tap
	task automatic test_zero_interval();
		write_reg(REG_TAP_INTERVAL, 12'd0);
		send_row(32'b101, 3, 1'b1);
	endtask

	task automatic test_phase_extremes();
		write_config(12'd4095, 12'd4094, 7'd64);
		send_row(32'b111, 3, 1'b1);
	endtask

	// interval shrinks below the running phase mid-row; new phase loads at column 0
	task automatic test_shrunk_interval();
		write_config(12'd10, 12'd0, 7'd1);
		send_row(32'hf, 4, 1'b0);
		write_reg(REG_TAP_INTERVAL, 12'd3);
		write_reg(REG_TAP_PHASE, 12'd2);
		send_row(32'h7, 3, 1'b1);
		send_row(32'h3, 2, 1'b1);
	endtask

	task automatic test_random_rows(input int n_items);
		int sent;
		int row_left;
		int stretch;
		bit free;
		logic [11:0] iv;
		logic [11:0] ph;
		logic [CW_W-1:0] w;
		sent = 0;
		row_left = 0;
		stretch = 0;
		free = 1'b0;
		while (sent < n_items) begin
			iv = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(17, 4095))
			                                 : 12'($urandom_range(2, 16));
			ph = ($urandom_range(0, 2) == 0) ? 12'($urandom_range(0, 4094))
			                                 : 12'($urandom_range(0, iv - 1));
			w = ($urandom_range(0, 3) == 0) ? CW_W'($urandom_range(1, 64))
			                                : CW_W'($urandom_range(1, 6));
			write_config(iv, ph, w);
			repeat ($urandom_range(25, 50)) begin
				if (row_left == 0)
					row_left = $urandom_range(1, 48);
				if (stretch == 0) begin
					free = !free;
					stretch = free ? $urandom_range(1, 20) : $urandom_range(1, 4);
				end
				send_site(free ^ ($urandom_range(0, 15) == 0), row_left == 1);
				row_left--;
				stretch--;
				sent++;
			end
		end
	endtask

	// receiver: ready pattern switches mode at random intervals
	always @(posedge clk) begin
		if (rx_span == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
			rx_span <= $urandom_range(20, 120);
		end else
			rx_span <= rx_span - 1;
		rx_tick <= rx_tick + 8'd1;
		case (rx_mode)
			RX_OPEN:   m_tready <= 1'b1;
			RX_THIRDS: m_tready <= (rx_tick % 3 == 0);
			RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
			default:   m_tready <= (rx_tick[3:0] > 4'd9);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			taps_checked++;
			if (pending_taps.size() == 0)
				report_mismatch($sformatf("unexpected tap col %0d kind %0d",
				                          m_tdata[11:0], m_tuser));
			else begin
				want = pending_taps.pop_front();
				if (m_tdata[11:0] !== want.col)
					report_mismatch($sformatf("tap_col %0d, want %0d",
					                          m_tdata[11:0], want.col));
				if (m_tuser !== want.kind)
					report_mismatch($sformatf("tap_kind %0d, want %0d at col %0d",
					                          m_tuser, want.kind, want.col));
				if (m_tlast !== want.last)
					report_mismatch($sformatf("last_of_run %0b, want %0b at col %0d",
					                          m_tlast, want.last, want.col));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			quiet_cycles <= 0;
		else if (quiet_cycles == QUIET_LIMIT) begin
			$display("%0t no transfer for %0d cycles, %0d taps outstanding",
			         $time, QUIET_LIMIT, pending_taps.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		test_defaults();
		test_end_taps();
		test_clamp_repeat();
		test_zero_interval();
		test_phase_extremes();
		test_shrunk_interval();
		test_random_rows(160);
		settle();
		$display("sites sent %0d, taps compared %0d, register writes %0d",
		         sites_sent, taps_checked, reg_writes);
		$display("directed end-tap cases and random rows under bursty input and stalls");
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
